/* rtl/core/cppc_pkg.sv */
// ----------------------------------------------------------------------------
// cppc_pkg
// Shared types and constants of the peak-to-peak coupling check.
// ----------------------------------------------------------------------------
package cppc_pkg;

  localparam int TRACE_LEN   = 1024;
  localparam int MAX_SENSORS = 32;

  localparam int SAMPLE_W = 12;
  localparam int SENSOR_W = 5;
  localparam int POS_W    = 11;
  localparam int THR_W    = 12;
  localparam int COUNT_W  = 6;
  localparam int MASK_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // position saturates at the smaller of the trace length minus one and 2047
  localparam int POS_CAP_INT = (TRACE_LEN - 1 < 2047) ? (TRACE_LEN - 1) : 2047;
  localparam logic [POS_W-1:0]   POS_CAP       = POS_W'(POS_CAP_INT);
  localparam logic [COUNT_W-1:0] MAX_SENSORS_C = COUNT_W'(MAX_SENSORS);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 12'sh7FF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 12'sh800;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START  = 3'd0,
    CFG_WINDOW_END    = 3'd1,
    CFG_AMP_THRESHOLD = 3'd2,
    CFG_PASS_FLOOR    = 3'd3,
    CFG_ACTIVE_MASK   = 3'd4,
    CFG_SENSOR_COUNT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]   window_start;
    logic [POS_W-1:0]   window_end;
    logic [THR_W-1:0]   amp_threshold;
    logic [COUNT_W-1:0] pass_floor;
    logic [MASK_W-1:0]  active_mask;
    logic [COUNT_W-1:0] sensor_count;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [SENSOR_W-1:0]        sensor_index;
    logic                       capture_failed;
    logic                       trace_end;
    logic                       scan_end;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]  coupled_mask;
    logic [COUNT_W-1:0] good_count;
    logic               coupling_error;
  } result_t;

endpackage

/* rtl/core/cppc_stream_if.sv */
// ----------------------------------------------------------------------------
// cppc stream interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface cppc_in_if import cppc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [SENSOR_W-1:0]        sensor_index;
  logic                       capture_failed;
  logic                       trace_end;
  logic                       scan_end;

  modport source (output valid, sample, sensor_index, capture_failed, trace_end, scan_end,
                  input ready);
  modport sink   (input valid, sample, sensor_index, capture_failed, trace_end, scan_end,
                  output ready);
endinterface

interface cppc_out_if import cppc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  coupled_mask;
  logic [COUNT_W-1:0] good_count;
  logic               coupling_error;

  modport source (output valid, coupled_mask, good_count, coupling_error, input ready);
  modport sink   (input valid, coupled_mask, good_count, coupling_error, output ready);
endinterface

interface cppc_cfg_if import cppc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/cppc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cppc_cfg_regs
// Register file for window, threshold, pass floor and sensor selection settings.
// ----------------------------------------------------------------------------
module cppc_cfg_regs import cppc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  cppc_cfg_if.sink        cfg_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_WINDOW_START:  cfg_d.window_start  = cfg_i.data[POS_W-1:0];
        CFG_WINDOW_END:    cfg_d.window_end    = cfg_i.data[POS_W-1:0];
        CFG_AMP_THRESHOLD: cfg_d.amp_threshold = cfg_i.data[THR_W-1:0];
        CFG_PASS_FLOOR:    cfg_d.pass_floor    = cfg_i.data[COUNT_W-1:0];
        CFG_ACTIVE_MASK:   cfg_d.active_mask   = cfg_i.data[MASK_W-1:0];
        CFG_SENSOR_COUNT:  cfg_d.sensor_count  = cfg_i.data[COUNT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_start  <= POS_W'(200);
      cfg_q.window_end    <= POS_W'(974);
      cfg_q.amp_threshold <= THR_W'(500);
      cfg_q.pass_floor    <= COUNT_W'(3);
      cfg_q.active_mask   <= '1;
      cfg_q.sensor_count  <= COUNT_W'(32);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/cppc_trace_eval.sv */
// ----------------------------------------------------------------------------
// cppc_trace_eval
// Per-trace min/max tracking, sensor judgement and scan accumulation.
// ----------------------------------------------------------------------------
module cppc_trace_eval import cppc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [POS_W-1:0]           pos_q, pos_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d, min_upd;
  logic signed [SAMPLE_W-1:0] max_q, max_d, max_upd;
  logic [MASK_W-1:0]          mask_q, mask_d, mask_upd;
  logic [COUNT_W-1:0]         cnt_q, cnt_d, cnt_upd;

  logic                 in_window;
  logic                 trace_done;
  logic [COUNT_W-1:0]   limit;
  logic                 eligible;
  logic signed [SAMPLE_W:0] p2p;
  logic                 good_new;

  always_comb begin
    in_window  = (pos_q >= cfg_i.window_start) && (pos_q < cfg_i.window_end);
    min_upd    = (in_window && item_i.sample < min_q) ? item_i.sample : min_q;
    max_upd    = (in_window && item_i.sample > max_q) ? item_i.sample : max_q;
    trace_done = item_i.trace_end || item_i.scan_end;

    limit    = (cfg_i.sensor_count < MAX_SENSORS_C) ? cfg_i.sensor_count : MAX_SENSORS_C;
    eligible = ({1'b0, item_i.sensor_index} < limit) &&
               cfg_i.active_mask[item_i.sensor_index] && !item_i.capture_failed;

    // empty window leaves max below min, so p2p goes negative
    p2p      = $signed({max_upd[SAMPLE_W-1], max_upd}) - $signed({min_upd[SAMPLE_W-1], min_upd});
    good_new = trace_done && eligible && (p2p >= $signed({1'b0, cfg_i.amp_threshold})) &&
               !mask_q[item_i.sensor_index];

    mask_upd = mask_q | (good_new ? (MASK_W'(1) << item_i.sensor_index) : '0);
    cnt_upd  = cnt_q + COUNT_W'(good_new);

    pos_d  = pos_q;
    min_d  = min_q;
    max_d  = max_q;
    mask_d = mask_q;
    cnt_d  = cnt_q;
    if (step_i) begin
      if (trace_done) begin
        pos_d = '0;
        min_d = SAMPLE_MAX;
        max_d = SAMPLE_MIN;
      end else begin
        pos_d = (pos_q < POS_CAP) ? pos_q + POS_W'(1) : pos_q;
        min_d = min_upd;
        max_d = max_upd;
      end
      if (item_i.scan_end) begin
        mask_d = '0;
        cnt_d  = '0;
      end else begin
        mask_d = mask_upd;
        cnt_d  = cnt_upd;
      end
    end

    res_o.coupled_mask   = mask_upd;
    res_o.good_count     = cnt_upd;
    res_o.coupling_error = (cnt_upd < cfg_i.pass_floor);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      min_q  <= SAMPLE_MAX;
      max_q  <= SAMPLE_MIN;
      mask_q <= '0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      min_q  <= min_d;
      max_q  <= max_d;
      mask_q <= mask_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/core/coupling_peak_to_peak_check.sv */
// ----------------------------------------------------------------------------
// coupling_peak_to_peak_check
// Windowed peak-to-peak coupling check over a scan of sensor echo traces.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one echo sample per item with its sensor index and the
//   capture_failed, trace_end and scan_end flags. Samples whose position in
//   the trace lies in [window_start, window_end) feed a running min/max; at
//   trace end the sensor is judged and its bit set in the coupled mask.
//   out_o gives one result per scan (mask, count, error flag), taken from the
//   item that carries scan_end. cfg_i writes the six registers by index; it
//   is always ready and is only to be used while the block is idle.
//   Throughput is one item per cycle while no scan_end item waits on a
//   stalled result. A scan_end item sits in the input register; as it steps
//   on, its result is loaded into the result register and out_o shows it.
//   Only the scan_end item waits on a stalled result; while out_o is held
//   the input keeps flowing until the next scan_end item reaches the input
//   register, which then holds until the result is taken.
//   Reset clears trace and scan state and loads the register defaults.
// ----------------------------------------------------------------------------
module coupling_peak_to_peak_check import cppc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cppc_cfg_if.sink   cfg_i,
  cppc_in_if.sink    in_i,
  cppc_out_if.source out_o
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  result_t res_next;
  result_t res_q;
  logic    out_valid_q, out_valid_d;
  logic    step;
  logic    load_out;
  logic    in_fire;

  cppc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cppc_trace_eval u_trace_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  // non-final items never wait on the result register
  assign step     = in_valid_q && (!item_q.scan_end || !out_valid_q || out_o.ready);
  assign load_out = step && item_q.scan_end;
  assign in_i.ready = !in_valid_q || step;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.sample         <= in_i.sample;
      item_q.sensor_index   <= in_i.sensor_index;
      item_q.capture_failed <= in_i.capture_failed;
      item_q.trace_end      <= in_i.trace_end;
      item_q.scan_end       <= in_i.scan_end;
    end
    if (load_out) begin
      res_q <= res_next;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.coupled_mask   = res_q.coupled_mask;
  assign out_o.good_count     = res_q.good_count;
  assign out_o.coupling_error = res_q.coupling_error;

`ifndef SYNTHESIS
  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.good_count == COUNT_W'($countones(res_q.coupled_mask))))
    else $error("good_count disagrees with coupled_mask");

  a_error_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (res_q.coupling_error == (res_q.good_count < cfg.pass_floor)))
    else $error("coupling_error inconsistent with good_count");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(item_q)))
    else $error("stalled input item lost or changed");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !load_out)
    else $error("pending result overwritten");
`endif

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives sensor echo scans through coupling_peak_to_peak_check and compares
// every per-scan result (coupled mask, good count, error flag) against a
// cycle-free predictor of the windowed min/max tracking, with random idling
// on both channels, a long result-side stall and several register settings.
// ----------------------------------------------------------------------------
module testbench import cppc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 4;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS     = 5_000_000;

  logic clk_i;
  logic rst_ni;

  cppc_cfg_if cfg_if ();
  cppc_in_if  in_if ();
  cppc_out_if out_if ();

  coupling_peak_to_peak_check i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // stimulus and expected scan reports
  item_t   pending_q[$];
  result_t scan_reports_q[$];
  int      err_count;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        rx_hold;
  logic        hold_go;

  // predictor state
  cfg_t                       cfg_shadow;
  logic [POS_W-1:0]           trk_pos;
  logic signed [SAMPLE_W-1:0] trk_min;
  logic signed [SAMPLE_W-1:0] trk_max;
  logic [MASK_W-1:0]          scan_mask;
  logic [COUNT_W-1:0]         scan_good;

  item_t   drv_item;
  result_t want_report;

  always #5 clk_i = ~clk_i;

  // advance the trace/scan tracker by one accepted sample
  task automatic track_sample(input item_t it);
    logic [COUNT_W-1:0] limit;
    logic               ends;
    result_t            rep;
    ends  = it.trace_end || it.scan_end;
    limit = (cfg_shadow.sensor_count < MAX_SENSORS_C) ? cfg_shadow.sensor_count
                                                      : MAX_SENSORS_C;
    if (trk_pos >= cfg_shadow.window_start && trk_pos < cfg_shadow.window_end) begin
      if (it.sample < trk_min) trk_min = it.sample;
      if (it.sample > trk_max) trk_max = it.sample;
    end
    if (trk_pos < POS_CAP) trk_pos = trk_pos + 1'b1;
    if (ends) begin
      // sensor and failure flag come from the item that closes the trace
      if ({1'b0, it.sensor_index} < limit && cfg_shadow.active_mask[it.sensor_index] &&
          !it.capture_failed &&
          (int'(trk_max) - int'(trk_min) >= int'(cfg_shadow.amp_threshold)) &&
          !scan_mask[it.sensor_index]) begin
        scan_mask[it.sensor_index] = 1'b1;
        scan_good = scan_good + 1'b1;
      end
      trk_pos = '0;
      trk_min = SAMPLE_MAX;
      trk_max = SAMPLE_MIN;
    end
    if (it.scan_end) begin
      rep.coupled_mask   = scan_mask;
      rep.good_count     = scan_good;
      rep.coupling_error = (scan_good < cfg_shadow.pass_floor);
      scan_reports_q.push_back(rep);
      scan_mask = '0;
      scan_good = '0;
    end
  endtask

  task automatic queue_sample(input int val, input int sensor, input bit failed,
                              input bit t_end, input bit s_end);
    item_t it;
    it.sample         = val[SAMPLE_W-1:0];
    it.sensor_index   = sensor[SENSOR_W-1:0];
    it.capture_failed = failed;
    it.trace_end      = t_end;
    it.scan_end       = s_end;
    pending_q.push_back(it);
  endtask

  // one well-formed scan with random content; amplitudes cluster near threshold
  task automatic queue_scan(input int n_traces, input int max_len);
    int sensor, len, span, lo, val, thr, t, i;
    bit failed, last_trace;
    sensor = $urandom_range(0, 31);
    thr    = int'(cfg_shadow.amp_threshold);
    for (t = 0; t < n_traces; t++) begin
      if ($urandom_range(0, 4) != 0) sensor = $urandom_range(0, 31);
      failed     = ($urandom_range(0, 9) == 0);
      len        = $urandom_range(1, max_len);
      last_trace = (t == n_traces - 1);
      case ($urandom_range(0, 3))
        0:       span = thr + int'($urandom_range(0, 2)) - 1;
        1:       span = int'($urandom_range(0, 4095));
        default: span = thr + int'($urandom_range(0, 200)) - 100;
      endcase
      if (span < 0) span = 0;
      if (span > 4095) span = 4095;
      lo = int'($urandom_range(0, 4095 - span)) - 2048;
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0:       val = lo;
          1:       val = lo + span;
          default: val = lo + int'($urandom_range(0, span));
        endcase
        if (i == len - 1) begin
          // scan end may come without trace end
          queue_sample(val, sensor, failed, !last_trace || $urandom_range(0, 1), last_trace);
        end else if ($urandom_range(0, 7) == 0) begin
          queue_sample(val, $urandom_range(0, 31), $urandom_range(0, 1), 1'b0, 1'b0);
        end else begin
          queue_sample(val, sensor, failed, 1'b0, 1'b0);
        end
      end
    end
  endtask

  // called right after a rising edge; leaves cfg valid high for back-to-back writes
  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_WINDOW_START:  cfg_shadow.window_start  = val[POS_W-1:0];
      CFG_WINDOW_END:    cfg_shadow.window_end    = val[POS_W-1:0];
      CFG_AMP_THRESHOLD: cfg_shadow.amp_threshold = val[THR_W-1:0];
      CFG_PASS_FLOOR:    cfg_shadow.pass_floor    = val[COUNT_W-1:0];
      CFG_ACTIVE_MASK:   cfg_shadow.active_mask   = val[MASK_W-1:0];
      CFG_SENSOR_COUNT:  cfg_shadow.sensor_count  = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_settings(input cfg_t c);
    write_register(CFG_WINDOW_START,  CFG_DATA_W'(c.window_start));
    write_register(CFG_WINDOW_END,    CFG_DATA_W'(c.window_end));
    write_register(CFG_AMP_THRESHOLD, CFG_DATA_W'(c.amp_threshold));
    write_register(CFG_PASS_FLOOR,    CFG_DATA_W'(c.pass_floor));
    write_register(CFG_ACTIVE_MASK,   CFG_DATA_W'(c.active_mask));
    write_register(CFG_SENSOR_COUNT,  CFG_DATA_W'(c.sensor_count));
    cfg_if.valid <= 1'b0;
  endtask

  // all items taken and all reports seen, then a settling wait for trailing work
  task automatic wait_scan_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_if.valid || scan_reports_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        drv_item.sample         = in_if.sample;
        drv_item.sensor_index   = in_if.sensor_index;
        drv_item.capture_failed = in_if.capture_failed;
        drv_item.trace_end      = in_if.trace_end;
        drv_item.scan_end       = in_if.scan_end;
        track_sample(drv_item);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = pending_q.pop_front();
          in_if.valid          <= 1'b1;
          in_if.sample         <= drv_item.sample;
          in_if.sensor_index   <= drv_item.sensor_index;
          in_if.capture_failed <= drv_item.capture_failed;
          in_if.trace_end      <= drv_item.trace_end;
          in_if.scan_end       <= drv_item.scan_end;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (scan_reports_q.size() == 0) begin
        $display("%0t: unexpected result mask=%h count=%0d error=%0b", $time,
                 out_if.coupled_mask, out_if.good_count, out_if.coupling_error);
        err_count++;
      end else begin
        want_report = scan_reports_q.pop_front();
        if (out_if.coupled_mask !== want_report.coupled_mask) begin
          $display("%0t: coupled_mask expected %h actual %h", $time,
                   want_report.coupled_mask, out_if.coupled_mask);
          err_count++;
        end
        if (out_if.good_count !== want_report.good_count) begin
          $display("%0t: good_count expected %0d actual %0d", $time,
                   want_report.good_count, out_if.good_count);
          err_count++;
        end
        if (out_if.coupling_error !== want_report.coupling_error) begin
          $display("%0t: coupling_error expected %0b actual %0b", $time,
                   want_report.coupling_error, out_if.coupling_error);
          err_count++;
        end
      end
    end
    out_if.ready <= rst_ni && !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long result-side stall so the block backs up into its input
  initial begin
    int held;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    for (held = 0; held < RX_HOLD_CYCLES; held++) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cfg_t rc;
    int   k, ws, we, i;
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    rx_hold = 1'b0;
    hold_go = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.sensor_index   = '0;
    in_if.capture_failed = 1'b0;
    in_if.trace_end      = 1'b0;
    in_if.scan_end       = 1'b0;
    out_if.ready = 1'b0;
    err_count    = 0;
    send_idle_pct = 37;
    recv_idle_pct = 49;

    cfg_shadow.window_start  = 11'd200;
    cfg_shadow.window_end    = 11'd974;
    cfg_shadow.amp_threshold = 12'd500;
    cfg_shadow.pass_floor    = 6'd3;
    cfg_shadow.active_mask   = '1;
    cfg_shadow.sensor_count  = 6'd32;
    trk_pos   = '0;
    trk_min   = SAMPLE_MAX;
    trk_max   = SAMPLE_MIN;
    scan_mask = '0;
    scan_good = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register defaults need long traces to reach the window
    @(negedge clk_i);
    queue_scan(1, 300);
    wait_scan_idle();

    // directed scan: tight window, full-scale threshold
    rc.window_start  = 11'd1;
    rc.window_end    = 11'd3;
    rc.amp_threshold = 12'd4095;
    rc.pass_floor    = 6'd32;
    rc.active_mask   = ~32'h2;
    rc.sensor_count  = 6'd31;
    write_settings(rc);
    @(negedge clk_i);
    // full swing in window; mid-trace sensor and failure flag are not used
    queue_sample(2047, 31, 1'b1, 1'b0, 1'b0);
    queue_sample(-2048, 31, 1'b1, 1'b0, 1'b0);
    queue_sample(2047, 0, 1'b0, 1'b1, 1'b0);
    // same sensor again, counted once
    queue_sample(0, 0, 1'b0, 1'b0, 1'b0);
    queue_sample(-2048, 0, 1'b0, 1'b0, 1'b0);
    queue_sample(2047, 0, 1'b0, 1'b1, 1'b0);
    // inactive sensor
    queue_sample(0, 1, 1'b0, 1'b0, 1'b0);
    queue_sample(-2048, 1, 1'b0, 1'b0, 1'b0);
    queue_sample(2047, 1, 1'b0, 1'b1, 1'b0);
    // capture failed on the closing item
    queue_sample(0, 30, 1'b0, 1'b0, 1'b0);
    queue_sample(-2048, 30, 1'b0, 1'b0, 1'b0);
    queue_sample(2047, 30, 1'b1, 1'b1, 1'b0);
    // index at sensor_count, out of range
    queue_sample(0, 31, 1'b0, 1'b0, 1'b0);
    queue_sample(-2048, 31, 1'b0, 1'b0, 1'b0);
    queue_sample(2047, 31, 1'b0, 1'b1, 1'b0);
    // single-sample trace, empty window
    queue_sample(2047, 2, 1'b0, 1'b1, 1'b0);
    // one count short of threshold, closed by scan end alone
    queue_sample(0, 3, 1'b0, 1'b0, 1'b0);
    queue_sample(-2048, 3, 1'b0, 1'b0, 1'b0);
    queue_sample(2046, 3, 1'b0, 1'b0, 1'b1);
    wait_scan_idle();

    for (k = 0; k < 12; k++) begin
      if (k == 0) begin
        rc.window_start  = 11'd0;
        rc.window_end    = 11'd1024;
        rc.amp_threshold = 12'd0;
        rc.pass_floor    = 6'd32;
        rc.active_mask   = '1;
        rc.sensor_count  = 6'd32;
      end else if (k == 1) begin
        rc.window_start  = 11'd1024;
        rc.window_end    = 11'd0;
        rc.amp_threshold = 12'd4095;
        rc.pass_floor    = 6'd0;
        rc.active_mask   = '0;
        rc.sensor_count  = 6'd0;
      end else begin
        case ($urandom_range(0, 9))
          0:       ws = 0;
          1:       ws = 1024;
          default: ws = $urandom_range(0, 8);
        endcase
        case ($urandom_range(0, 9))
          0:       we = 0;
          1:       we = 1024;
          default: we = ws + int'($urandom_range(0, 10));
        endcase
        if (we > 1024) we = 1024;
        rc.window_start = 11'(ws);
        rc.window_end   = 11'(we);
        case ($urandom_range(0, 9))
          0:         rc.amp_threshold = 12'd0;
          1:         rc.amp_threshold = 12'd4095;
          2, 3, 4:   rc.amp_threshold = 12'($urandom_range(0, 300));
          default:   rc.amp_threshold = 12'($urandom_range(0, 4095));
        endcase
        case ($urandom_range(0, 9))
          0:       rc.pass_floor = 6'd0;
          1:       rc.pass_floor = 6'd32;
          default: rc.pass_floor = 6'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 9))
          0:       rc.active_mask = '0;
          1:       rc.active_mask = '1;
          default: rc.active_mask = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0:       rc.sensor_count = 6'd0;
          1:       rc.sensor_count = 6'd32;
          default: rc.sensor_count = 6'($urandom_range(0, 32));
        endcase
      end

      if (k == 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 37;
        // overlong trace: extremes only after the position has saturated
        rc.window_start  = 11'd1000;
        rc.window_end    = 11'd1024;
        rc.amp_threshold = 12'd150;
        rc.pass_floor    = 6'd1;
        rc.active_mask   = '1;
        rc.sensor_count  = 6'd32;
        write_settings(rc);
        @(negedge clk_i);
        for (i = 0; i < 1026; i++) begin
          queue_sample((i == 1024) ? 100 : (i == 1025) ? -100 : 0, 5, 1'b0,
                       i == 1025, i == 1025);
        end
        wait_scan_idle();
        // the random scan below then runs with these same settings
        k = k;
      end

      write_settings(rc);
      @(negedge clk_i);
      if (k == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_scan($urandom_range(1, 4), 12);
      wait_scan_idle();
    end

    // back-pressure: receiver holds off while short scans pour in
    @(negedge clk_i);
    hold_go = 1'b1;
    for (i = 0; i < 10; i++) queue_scan($urandom_range(1, 2), 3);
    wait_scan_idle();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/cppc_pkg.sv
rtl/core/cppc_stream_if.sv
rtl/core/cppc_cfg_regs.sv
rtl/core/cppc_trace_eval.sv
rtl/core/coupling_peak_to_peak_check.sv
tb/sv/testbench.sv
